>>> hw/rtl/positional_array_table_defines.svh
// ----------------------------------------------------------------------------
// positional array table assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_TABLE_DEFINES_SVH
`define POSITIONAL_ARRAY_TABLE_DEFINES_SVH

// property sampled on clk, ignored while rst is high
`define PAT_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");

// property sampled on clk, also checked during reset
`define PAT_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: reset property failed");

`endif

>>> hw/rtl/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg
// request modes, status codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam logic [2:0] MODE_INSERT  = 3'd0;
  localparam logic [2:0] MODE_DELETE  = 3'd1;
  localparam logic [2:0] MODE_REPLACE = 3'd2;
  localparam logic [2:0] MODE_SEARCH  = 3'd3;
  localparam logic [2:0] MODE_DISPLAY = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_POS   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam logic [1:0] ELEM_VALUE = 2'd0;
  localparam logic [1:0] ELEM_ENTRY = 2'd1;
  localparam logic [1:0] ELEM_ZERO  = 2'd2;

  localparam logic [1:0] IDX_POS  = 2'd0;
  localparam logic [1:0] IDX_WALK = 2'd1;
  localparam logic [1:0] IDX_ZERO = 2'd2;

  typedef struct packed {
    logic       load;
    logic       walk_clr;
    logic       walk_inc;
    logic       rd_pos;
    logic       wr_insert;
    logic       wr_delete;
    logic       wr_replace;
    logic       emit;
    logic [2:0] status;
    logic [1:0] elem_sel;
    logic [1:0] idx_sel;
    logic       last;
  } pat_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       full;
    logic       empty;
    logic       pos_ok;
    logic       ins_pos_ok;
    logic       match;
    logic       walk_last;
    logic       out_free;
  } pat_stat_t;

endpackage

>>> hw/rtl/positional_array_table.sv
// ----------------------------------------------------------------------------
// positional_array_table
// ordered table of signed words with insert, delete, replace, search, display
// ----------------------------------------------------------------------------
// usage
//   requests enter on the slave stream: s_tuser carries the mode, s_tdata the
//   value and the 1-based position. results leave on the master stream:
//   m_tuser carries the status, m_tdata the element, index and count, and
//   m_tlast marks the final result of a request.
//   insert, delete and replace register their result in the exec state once
//   the output register is free; no request is taken until it is loaded.
//   search walks the table one entry a cycle and stops at the first entry
//   that matches, or after the last entry when nothing matches.
//   display emits one result per entry, one per cycle unless stalled.
//   requests are handled one at a time; s_tready is high while the
//   sequencer is idle, which it becomes as soon as the final result is
//   loaded into the output register, so the next request is taken while
//   that result still waits on m_tready.
//   a stalled receiver holds the output register; new results wait on it.
//   reset clears the count and the handshake state; entry contents are left
//   as they were and are only read below the count.
// ----------------------------------------------------------------------------
module positional_array_table #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value [31:0], position [37:32], zero fill
  input  logic [2:0]  s_tuser,   // mode [2:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // element [31:0], index [36:32], count [42:37]
  output logic [2:0]  m_tuser,   // status [2:0]
  output logic        m_tlast
);
  import pat_pkg::*;

  pat_cmd_t           cmd;
  pat_stat_t          stat;
  logic signed [31:0] out_element;
  logic [4:0]         out_index;
  logic [5:0]         out_count;

  // sequencer: decodes the request and steps the walks
  pat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // entry store, count, walk index and output register
  pat_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_mode     (s_tuser),
    .in_value    (s_tdata[31:0]),
    .in_position (s_tdata[37:32]),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_status  (m_tuser),
    .out_element (out_element),
    .out_index   (out_index),
    .out_count   (out_count),
    .out_last    (m_tlast)
  );

  // pack result fields from the lowest bit up
  assign m_tdata = {5'd0, out_count, out_index, out_element};

endmodule

>>> hw/rtl/pat_ctrl.sv
// ----------------------------------------------------------------------------
// pat_ctrl
// request sequencer: decodes the mode and steps search and display walks
// ----------------------------------------------------------------------------
module pat_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pat_pkg::pat_stat_t  stat,
  output pat_pkg::pat_cmd_t   cmd
);
  import pat_pkg::*;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EXEC    = 2'd1;
  localparam logic [1:0] S_SEARCH  = 2'd2;
  localparam logic [1:0] S_DISPLAY = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.last   = 1'b1;
          state_next = S_IDLE;
          case (stat.mode)
            MODE_INSERT: begin
              cmd.emit = 1'b1;
              if (stat.full) begin
                cmd.status   = ST_FULL;
                cmd.elem_sel = ELEM_VALUE;
                cmd.idx_sel  = IDX_ZERO;
              end else if (!stat.ins_pos_ok) begin
                cmd.status   = ST_BAD_POS;
                cmd.elem_sel = ELEM_VALUE;
                cmd.idx_sel  = IDX_ZERO;
              end else begin
                cmd.wr_insert = 1'b1;
                cmd.status    = ST_OK;
                cmd.elem_sel  = ELEM_VALUE;
                cmd.idx_sel   = IDX_POS;
              end
            end
            MODE_DELETE: begin
              cmd.emit = 1'b1;
              if (!stat.pos_ok) begin
                cmd.status   = ST_BAD_POS;
                cmd.elem_sel = ELEM_ZERO;
                cmd.idx_sel  = IDX_ZERO;
              end else begin
                cmd.wr_delete = 1'b1;
                cmd.rd_pos    = 1'b1;
                cmd.status    = ST_OK;
                cmd.elem_sel  = ELEM_ENTRY;
                cmd.idx_sel   = IDX_POS;
              end
            end
            MODE_REPLACE: begin
              cmd.emit = 1'b1;
              if (!stat.pos_ok) begin
                cmd.status   = ST_BAD_POS;
                cmd.elem_sel = ELEM_VALUE;
                cmd.idx_sel  = IDX_ZERO;
              end else begin
                cmd.wr_replace = 1'b1;
                cmd.status     = ST_OK;
                cmd.elem_sel   = ELEM_VALUE;
                cmd.idx_sel    = IDX_POS;
              end
            end
            MODE_SEARCH: begin
              if (stat.empty) begin
                cmd.emit     = 1'b1;
                cmd.status   = ST_NOT_FOUND;
                cmd.elem_sel = ELEM_VALUE;
                cmd.idx_sel  = IDX_ZERO;
              end else begin
                cmd.last     = 1'b0;
                cmd.walk_clr = 1'b1;
                state_next   = S_SEARCH;
              end
            end
            MODE_DISPLAY: begin
              if (stat.empty) begin
                cmd.emit     = 1'b1;
                cmd.status   = ST_EMPTY;
                cmd.elem_sel = ELEM_ZERO;
                cmd.idx_sel  = IDX_ZERO;
              end else begin
                cmd.last     = 1'b0;
                cmd.walk_clr = 1'b1;
                state_next   = S_DISPLAY;
              end
            end
            default: begin
              cmd.last = 1'b0;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (stat.match) begin
          if (stat.out_free) begin
            cmd.emit     = 1'b1;
            cmd.status   = ST_OK;
            cmd.elem_sel = ELEM_VALUE;
            cmd.idx_sel  = IDX_WALK;
            cmd.last     = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (stat.walk_last) begin
          if (stat.out_free) begin
            cmd.emit     = 1'b1;
            cmd.status   = ST_NOT_FOUND;
            cmd.elem_sel = ELEM_VALUE;
            cmd.idx_sel  = IDX_ZERO;
            cmd.last     = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.walk_inc = 1'b1;
        end
      end
      S_DISPLAY: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.status   = ST_OK;
          cmd.elem_sel = ELEM_ENTRY;
          cmd.idx_sel  = IDX_WALK;
          cmd.last     = stat.walk_last;
          if (stat.walk_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.walk_inc = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/pat_datapath.sv
// ----------------------------------------------------------------------------
// pat_datapath
// entry register file with parallel shift, walk index and result register
// ----------------------------------------------------------------------------
module pat_datapath #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  pat_pkg::pat_cmd_t   cmd,
  output pat_pkg::pat_stat_t  stat,
  input  logic [2:0]          in_mode,
  input  logic signed [31:0]  in_value,
  input  logic [5:0]          in_position,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [2:0]          out_status,
  output logic signed [31:0]  out_element,
  output logic [4:0]          out_index,
  output logic [5:0]          out_count,
  output logic                out_last
);
  import pat_pkg::*;

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > 6) ? CW : 6) + 1;

  logic [2:0]            mode_q;
  logic signed [31:0]    value_q;
  logic [5:0]            pos_q;
  logic [DATA_WIDTH-1:0] entries [DEPTH];
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [IW-1:0]         walk;

  logic [63:0]           sval64;
  logic [DATA_WIDTH-1:0] sval;
  logic [CMPW-1:0]       pos_w;
  logic [CMPW-1:0]       cnt_w;
  logic [5:0]            pos_m1;
  logic [IW-1:0]         pidx;
  logic [IW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] walk_data;
  logic [63:0]           ent64;
  logic [7:0]            idx8;
  logic [7:0]            cnt8;

  // request value sign-extended or cut to the stored width
  assign sval64    = 64'(value_q);
  assign sval      = sval64[DATA_WIDTH-1:0];
  assign pos_w     = CMPW'(pos_q);
  assign cnt_w     = CMPW'(count);
  assign pos_m1    = pos_q - 6'd1;
  assign pidx      = pos_m1[IW-1:0];
  assign rd_addr   = cmd.rd_pos ? pidx : walk;
  assign rd_data   = entries[rd_addr];
  // search compare port, independent of the command
  assign walk_data = entries[walk];
  assign ent64     = 64'(rd_data);

  always_comb begin
    stat.mode       = mode_q;
    stat.full       = (count == CW'(DEPTH));
    stat.empty      = (count == '0);
    stat.pos_ok     = (pos_q != 6'd0) && (pos_w <= cnt_w);
    stat.ins_pos_ok = (pos_q != 6'd0) && (pos_w <= cnt_w + CMPW'(1));
    stat.match      = (walk_data == sval);
    stat.walk_last  = (CW'(walk) + CW'(1) == count);
    stat.out_free   = !out_valid || out_ready;
  end

  always_comb begin
    count_next = count;
    if (cmd.wr_insert) begin
      count_next = count + CW'(1);
    end else if (cmd.wr_delete) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= in_mode;
      value_q <= in_value;
      pos_q   <= in_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_clr) begin
      walk <= '0;
    end else if (cmd.walk_inc) begin
      walk <= walk + IW'(1);
    end
  end

  // shifted entries take their lower neighbor on insert, the upper on delete
  for (genvar g = 0; g < DEPTH; g++) begin : g_ent
    logic [DATA_WIDTH-1:0] up_src;
    logic [DATA_WIDTH-1:0] dn_src;

    if (g == 0) begin : g_first
      assign up_src = sval;
    end else begin : g_mid
      assign up_src = entries[g-1];
    end
    if (g == DEPTH - 1) begin : g_top
      assign dn_src = entries[g];
    end else begin : g_below
      assign dn_src = entries[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.wr_insert) begin
        if (CMPW'(g) + CMPW'(1) == pos_w) begin
          entries[g] <= sval;
        end else if (CMPW'(g) >= pos_w) begin
          entries[g] <= up_src;
        end
      end else if (cmd.wr_delete) begin
        if (CMPW'(g) + CMPW'(1) >= pos_w) begin
          entries[g] <= dn_src;
        end
      end else if (cmd.wr_replace) begin
        if (CMPW'(g) + CMPW'(1) == pos_w) begin
          entries[g] <= sval;
        end
      end
    end
  end

  always_comb begin
    case (cmd.idx_sel)
      IDX_POS:  idx8 = 8'(pidx);
      IDX_WALK: idx8 = 8'(walk);
      default:  idx8 = 8'd0;
    endcase
  end

  assign cnt8 = 8'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.status;
      out_index  <= idx8[4:0];
      out_count  <= cnt8[5:0];
      out_last   <= cmd.last;
      case (cmd.elem_sel)
        ELEM_VALUE: out_element <= value_q;
        ELEM_ENTRY: out_element <= ent64[31:0];
        default:    out_element <= '0;
      endcase
    end
  end

endmodule

>>> hw/rtl/pat_checker.sv
// ----------------------------------------------------------------------------
// pat_checker
// port-level properties of the positional array table
// ----------------------------------------------------------------------------
`include "positional_array_table_defines.svh"

module pat_checker #(
  parameter int DEPTH = 32
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);
  import pat_pkg::*;

  // held transaction stays put until taken
  `PAT_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // output register is empty right after reset
  `PAT_ASSERT_RST(a_rst_clear, rst |=> !m_tvalid)

  // reported count never exceeds the table depth
  `PAT_ASSERT_CLK(a_count_max, m_tvalid |-> m_tdata[42:37] <= 6'(DEPTH))

  // a non-final display result means the walk is still busy
  `PAT_ASSERT_CLK(a_walk_busy, m_tvalid && !m_tlast |-> !s_tready && m_tuser == ST_OK)

endmodule

bind positional_array_table pat_checker #(.DEPTH(DEPTH)) u_pat_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
